### hw/rtl/rac_pkg.sv
// Package for the rational accumulator ALU: op codes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package rac_pkg;
  localparam int unsigned OpW = 3;
  localparam int unsigned StW = 2;
  localparam logic [OpW-1:0] OP_LOAD = 3'd0;
  localparam logic [OpW-1:0] OP_ADD  = 3'd1;
  localparam logic [OpW-1:0] OP_SUB  = 3'd2;
  localparam logic [OpW-1:0] OP_MUL  = 3'd3;
  localparam logic [OpW-1:0] OP_DIV  = 3'd4;
  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [StW-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_MUL3  = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;
endpackage
`default_nettype wire

### hw/rtl/rational_accumulator_alu.sv
// Rational accumulator ALU top level: sequencer around one 32x32 multiplier, a binary
// gcd unit and a shift/subtract divider. Depends on rac_pkg.
`default_nettype none
// A valid item passes the multiplier states MUL1 to MUL3, SUM, the binary gcd state GCD and
// the two bit-serial divisions DIVN and DIVD before OUT; a zero denominator, a division by
// zero or an unused op goes straight from idle to OUT. One item at a time: the next transfer
// is accepted only after the result is loaded, and a stalled result holds the sequencer.
// The shift/subtract divider produces one quotient bit per cycle.
// Reset clears the accumulator to 0/1, the sequencer to idle and drops the output valid.
module rational_accumulator_alu #(
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [71:0] s_axis_tdata_i,  // op[2:0], operand_num[34:3], operand_den[66:35], zeros
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // result_num[31:0], result_den[62:32], zero
  output logic [1:0]  m_axis_tuser_o   // status
);
  localparam int unsigned EffW = (FIELD_WIDTH < 8) ? 8 : ((FIELD_WIDTH > 32) ? 32 : FIELD_WIDTH);
  localparam logic [63:0] Lim = (64'd1 << (EffW - 1)) - 64'd1;

  rac_pkg::state_e state_q, state_d;
  logic [31:0] acc_num_q, acc_den_q;
  logic [2:0]  op_q;
  logic        an_neg_q, a_neg_q, b_neg_q;
  logic [31:0] an_q, a_q, b_q, ad_q;
  logic [63:0] p1_q, p2_q, p3_q; // products
  logic        p2_neg_q;
  logic [63:0] n_q, d_q;
  logic        n_neg_q;
  logic [63:0] gu_q, gv_q;
  logic [6:0]  gk_q;
  logic [63:0] quo_q, rem_q, dvs_q;
  logic [6:0]  cnt_q;
  logic [1:0]  st_q;
  logic [31:0] r_num_q;
  logic [30:0] r_den_q;
  logic [1:0]  r_st_q;
  logic        ovalid_q;

  wire [2:0]  in_op  = s_axis_tdata_i[2:0];
  wire [31:0] in_num = s_axis_tdata_i[34:3];
  wire [31:0] in_den = s_axis_tdata_i[66:35];
  wire        in_acc = s_axis_tvalid_i && s_axis_tready_o;
  wire        out_load = (state_q == rac_pkg::S_OUT) && (!ovalid_q || m_axis_tready_i);

  // shared multiplier
  logic [31:0] mx, my;
  wire  [63:0] mprod = 64'(mx) * 64'(my);
  always_comb begin
    mx = an_q; my = b_q;
    unique case (state_q)
      rac_pkg::S_MUL2: begin mx = a_q;  my = (op_q == rac_pkg::OP_MUL) ? 32'd0 : ad_q; end
      rac_pkg::S_MUL3: begin mx = ad_q; my = (op_q == rac_pkg::OP_DIV) ? a_q : b_q; end
      default: begin
        mx = (op_q == rac_pkg::OP_MUL) ? an_q : an_q;
        my = (op_q == rac_pkg::OP_MUL) ? a_q : b_q;
      end
    endcase
  end

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  wire [63:0] rem_sh  = {rem_q[62:0], quo_q[63]};
  wire [64:0] rem_sub = {1'b0, rem_sh} - {1'b0, dvs_q};
  wire [63:0] gdiff   = (gu_q > gv_q) ? gu_q - gv_q : gv_q - gu_q;
  wire [63:0] gmin    = (gu_q > gv_q) ? gv_q : gu_q;
  wire [63:0] gval    = gu_q << gk_q[5:0];

  // final checks on reduced values (n_q, d_q after both divisions)
  wire        fneg  = (n_q != 64'd0) && n_neg_q;
  wire        ovf_w = (d_q > Lim) || (n_q > (Lim + {63'd0, fneg}));
  wire [31:0] new_num = fneg ? (~n_q[31:0] + 32'd1) : n_q[31:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rac_pkg::S_IDLE: if (in_acc) begin
        if (in_op > rac_pkg::OP_DIV || in_den == 32'd0 ||
            (in_op == rac_pkg::OP_DIV && in_num == 32'd0)) state_d = rac_pkg::S_OUT;
        else state_d = rac_pkg::S_MUL1;
      end
      rac_pkg::S_MUL1: state_d = rac_pkg::S_MUL2;
      rac_pkg::S_MUL2: state_d = rac_pkg::S_MUL3;
      rac_pkg::S_MUL3: state_d = rac_pkg::S_SUM;
      rac_pkg::S_SUM:  state_d = rac_pkg::S_GCD;
      rac_pkg::S_GCD:  if (gu_q == 64'd0 || gv_q == 64'd0 || gu_q == gv_q)
                         state_d = rac_pkg::S_DIVN;
      rac_pkg::S_DIVN: if (cnt_q == 7'd64) state_d = rac_pkg::S_DIVD;
      rac_pkg::S_DIVD: if (cnt_q == 7'd64) state_d = rac_pkg::S_OUT;
      rac_pkg::S_OUT:  if (!ovalid_q || m_axis_tready_i) state_d = rac_pkg::S_IDLE;
      default: state_d = rac_pkg::S_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == rac_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rac_pkg::S_IDLE;
      acc_num_q <= 32'd0;
      acc_den_q <= 32'd1;
      ovalid_q  <= 1'b0;
      st_q      <= rac_pkg::ST_OK;
      r_st_q    <= rac_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      if (out_load) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        rac_pkg::S_IDLE: if (in_acc) begin
          op_q <= in_op;
          a_q <= mag32(in_num); a_neg_q <= in_num[31];
          b_q <= mag32(in_den); b_neg_q <= in_den[31];
          an_q <= mag32(acc_num_q); an_neg_q <= acc_num_q[31];
          ad_q <= acc_den_q;
          st_q <= (in_op > rac_pkg::OP_DIV) ? rac_pkg::ST_OK : rac_pkg::ST_ZERO_DEN;
        end
        rac_pkg::S_MUL1: p1_q <= mprod;
        rac_pkg::S_MUL2: begin
          p2_q <= mprod;
          p2_neg_q <= a_neg_q ^ (op_q == rac_pkg::OP_SUB);
        end
        rac_pkg::S_MUL3: p3_q <= mprod;
        rac_pkg::S_SUM: begin
          logic p1n, dn;
          logic [63:0] nm;
          logic nn;
          p1n = (op_q == rac_pkg::OP_MUL) ? (an_neg_q ^ a_neg_q) : (an_neg_q ^ b_neg_q);
          dn  = (op_q == rac_pkg::OP_DIV) ? a_neg_q : b_neg_q;
          nn  = p1n;
          nm  = p1_q;
          if (op_q == rac_pkg::OP_LOAD) begin
            nm = {32'd0, a_q}; nn = a_neg_q;
            d_q <= {32'd0, b_q}; dn = b_neg_q;
          end else d_q <= p3_q;
          if (op_q == rac_pkg::OP_ADD || op_q == rac_pkg::OP_SUB) begin
            if (p1_q == 64'd0) p1n = 1'b0;
            if (p1n == p2_neg_q || p2_q == 64'd0 || p1_q == 64'd0) begin
              nm = p1_q + p2_q;
              nn = (p1_q == 64'd0) ? p2_neg_q : p1n;
            end else if (p1_q >= p2_q) begin
              nm = p1_q - p2_q; nn = p1n;
            end else begin
              nm = p2_q - p1_q; nn = p2_neg_q;
            end
          end
          n_q <= nm;
          n_neg_q <= nn ^ dn;
          gu_q <= nm;
          gv_q <= (op_q == rac_pkg::OP_LOAD) ? {32'd0, b_q} : p3_q;
          gk_q <= 7'd0;
          st_q <= rac_pkg::ST_OK;
        end
        rac_pkg::S_GCD: begin
          // binary gcd: strip common twos, then subtract
          if (gu_q == 64'd0 || gv_q == 64'd0 || gu_q == gv_q) begin
            quo_q <= n_q; rem_q <= 64'd0; cnt_q <= 7'd0;
            dvs_q <= (gu_q == 64'd0) ? gv_q << gk_q[5:0] : gval;
          end else if (!gu_q[0] && !gv_q[0]) begin
            gu_q <= gu_q >> 1; gv_q <= gv_q >> 1; gk_q <= gk_q + 7'd1;
          end else if (!gu_q[0]) gu_q <= gu_q >> 1;
          else if (!gv_q[0]) gv_q <= gv_q >> 1;
          else begin gu_q <= gdiff; gv_q <= gmin; end
        end
        rac_pkg::S_DIVN, rac_pkg::S_DIVD: begin
          if (cnt_q == 7'd64) begin
            cnt_q <= 7'd0; rem_q <= 64'd0;
            if (state_q == rac_pkg::S_DIVN) begin
              n_q <= quo_q; quo_q <= d_q;
            end else begin
              d_q <= quo_q;
            end
          end else begin
            cnt_q <= cnt_q + 7'd1;
            if (!rem_sub[64]) begin
              rem_q <= rem_sub[63:0]; quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh; quo_q <= {quo_q[62:0], 1'b0};
            end
          end
        end
        rac_pkg::S_OUT: if (out_load) begin
          if (st_q == rac_pkg::ST_OK && op_q <= rac_pkg::OP_DIV && !ovf_w)
            begin acc_num_q <= new_num; acc_den_q <= d_q[31:0]; end
          r_num_q <= (st_q == rac_pkg::ST_OK && op_q <= rac_pkg::OP_DIV && !ovf_w)
                     ? new_num : acc_num_q;
          r_den_q <= (st_q == rac_pkg::ST_OK && op_q <= rac_pkg::OP_DIV && !ovf_w)
                     ? d_q[30:0] : acc_den_q[30:0];
          r_st_q  <= (st_q == rac_pkg::ST_OK && op_q <= rac_pkg::OP_DIV && ovf_w)
                     ? rac_pkg::ST_OVERFLOW : st_q;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {1'b0, r_den_q, r_num_q};
  assign m_axis_tuser_o  = r_st_q;

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_den_q != 32'd0 && !acc_den_q[31]) else $error("accumulator denominator invalid");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rac_pkg::S_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i && state_q != rac_pkg::S_OUT) |=> $stable(r_num_q))
    else $error("result changed while stalled");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (r_st_q != 2'd3)) else $error("bad status");
endmodule
`default_nettype wire

### test/rational_accumulator_alu_tb.sv
// Self-checking testbench for rational_accumulator_alu: stream driver, result monitor and a
// fraction predictor with its own accumulator copy. Depends on rac_pkg and the block.
module rational_accumulator_alu_tb;

  localparam int unsigned FW = 32;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0]             num;
    logic [30:0]             den;
    logic [rac_pkg::StW-1:0] st;
  } frac_res_t;

  typedef struct packed {
    logic           neg;
    logic [63:0]    mag;
  } smag_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_ready, m_valid;
  logic [63:0] m_data;
  logic [1:0]  m_user;

  logic [71:0] item_q[$];
  frac_res_t   frac_q[$];
  logic [31:0] acc_num_q = '0;
  logic [31:0] acc_den_q = 32'd1;
  int          n_sent = 0;
  int          n_errors = 0;
  int          quiet_cycles = 0;
  int          phase = 0;

  rational_accumulator_alu #(.FIELD_WIDTH(FW)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // op[2:0], operand_num[34:3], operand_den[66:35], zeros
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),   // result_num[31:0], result_den[62:32], zero
    .m_axis_tuser_o (m_user)    // status
  );

  always #4 clk_i = ~clk_i;

  function automatic smag_t to_smag(logic [31:0] v);
    smag_t r;
    r.neg = v[31];
    r.mag = v[31] ? {32'd0, -v} : {32'd0, v};
    return r;
  endfunction

  function automatic smag_t smag_mul(smag_t a, smag_t b);
    smag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  // Apply one operation to the accumulator copy and return the emitted fraction.
  function automatic frac_res_t apply_fraction_op(logic [rac_pkg::OpW-1:0] op,
                                                   logic [31:0] on, logic [31:0] od);
    smag_t a, b, an, ad, n, d, t;
    logic [63:0] g, x, y, r, lim;
    logic neg;
    frac_res_t res;
    a = to_smag(on);
    b = to_smag(od);
    an = to_smag(acc_num_q);
    ad = to_smag(acc_den_q);
    res.st = rac_pkg::ST_OK;
    if (op > rac_pkg::OP_DIV) begin
      res.st = rac_pkg::ST_OK;
    end else if (b.mag == 0 || (op == rac_pkg::OP_DIV && a.mag == 0)) begin
      res.st = rac_pkg::ST_ZERO_DEN;
    end else begin
      case (op)
        rac_pkg::OP_LOAD: begin n = a; d = b; end
        rac_pkg::OP_ADD, rac_pkg::OP_SUB: begin
          t = smag_mul(a, ad);
          if (op == rac_pkg::OP_SUB && t.mag != 0) t.neg = ~t.neg;
          n = smag_add(smag_mul(an, b), t);
          d = smag_mul(ad, b);
        end
        rac_pkg::OP_MUL: begin n = smag_mul(an, a); d = smag_mul(ad, b); end
        default: begin n = smag_mul(an, b); d = smag_mul(ad, a); end
      endcase
      x = n.mag;
      y = d.mag;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      g = x;
      n.mag = n.mag / g;
      d.mag = d.mag / g;
      neg = (n.mag != 0) && (n.neg != d.neg);
      lim = (64'd1 << (FW - 1)) - 64'd1;
      if (d.mag > lim || n.mag > lim + (neg ? 64'd1 : 64'd0)) begin
        res.st = rac_pkg::ST_OVERFLOW;
      end else begin
        acc_num_q = neg ? (~n.mag[31:0] + 32'd1) : n.mag[31:0];
        acc_den_q = d.mag[31:0];
      end
    end
    res.num = acc_num_q;
    res.den = acc_den_q[30:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic push_item(logic [rac_pkg::OpW-1:0] op, logic [31:0] on, logic [31:0] od);
    item_q.push_back({5'd0, od, on, op});
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Driver: hold the item until its transfer, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        frac_q.push_back(apply_fraction_op(s_data[2:0], s_data[34:3], s_data[66:35]));
        n_sent++;
        phase = (n_sent < 180) ? 0 : (n_sent < 360) ? 1 : 2;
      end
      if (!s_valid || s_ready) begin
        if (item_q.size() != 0 &&
            !((phase == 0 && $urandom_range(0, 99) < 38) ||
              (phase == 1 && $urandom_range(0, 99) < 66))) begin
          s_data  <= item_q.pop_front();
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    frac_res_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (frac_q.size() == 0) begin
          report_mismatch("unexpected result", m_data, 64'd0);
        end else begin
          want = frac_q.pop_front();
          if (m_data[31:0] !== want.num)
            report_mismatch("result_num", 64'(m_data[31:0]), 64'(want.num));
          if (m_data[62:32] !== want.den)
            report_mismatch("result_den", 64'(m_data[62:32]), 64'(want.den));
          if (m_user !== want.st) report_mismatch("status", 64'(m_user), 64'(want.st));
        end
      end
      m_ready <= !((phase == 0 && $urandom_range(0, 99) < 66) ||
                   (phase == 1 && $urandom_range(0, 99) < 38));
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [rac_pkg::OpW-1:0] op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, every op, zero denominator, divide by zero, overflow, zero result.
    push_item(rac_pkg::OP_ADD, 32'd1, 32'd2);
    push_item(rac_pkg::OP_LOAD, 32'h7fffffff, 32'd1);
    push_item(rac_pkg::OP_ADD, 32'd1, 32'd1);
    push_item(rac_pkg::OP_LOAD, 32'h80000000, 32'd1);
    push_item(rac_pkg::OP_LOAD, 32'd1, 32'h80000000);
    push_item(rac_pkg::OP_LOAD, 32'h80000000, 32'hffffffff);
    push_item(rac_pkg::OP_LOAD, 32'd6, 32'hfffffff7);
    push_item(rac_pkg::OP_SUB, 32'd1, 32'd3);
    push_item(rac_pkg::OP_SUB, 32'd5, 32'd7);
    push_item(rac_pkg::OP_MUL, 32'h7fffffff, 32'h7ffffffe);
    push_item(rac_pkg::OP_DIV, 32'd0, 32'd5);
    push_item(rac_pkg::OP_ADD, 32'd3, 32'd0);
    push_item(rac_pkg::OP_MUL, 32'd0, 32'd9);
    push_item(rac_pkg::OP_DIV, 32'd3, 32'd4);
    push_item(rac_pkg::OP_LOAD, 32'h7fffffff, 32'h7ffffffe);
    push_item(rac_pkg::OP_ADD, 32'h7fffffff, 32'h7fffffff);
    push_item(3'd5, 32'hffffffff, 32'hffffffff);
    push_item(3'd6, 32'd0, 32'd0);
    push_item(3'd7, 32'h12345678, 32'd1);
    push_item(rac_pkg::OP_LOAD, 32'hfffffffd, 32'd4);
    push_item(rac_pkg::OP_DIV, 32'hffffffff, 32'h80000000);
    push_item(rac_pkg::OP_SUB, 32'hfffffffd, 32'd4);
    for (int i = 0; i < 500; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      push_item(op, rand_operand(), rand_operand());
    end
    wait (item_q.size() == 0 && !s_valid);
    wait (frac_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && frac_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/rac_pkg.sv
hw/rtl/rational_accumulator_alu.sv
test/rational_accumulator_alu_tb.sv
